### hdl/rialu_pkg.sv
// Package: operation codes and word types for the integer ALU.
package rialu_pkg;

    // Divider pipe shape: DivSteps stages retire DivBits quotient bits each.
    localparam int unsigned DivSteps = 8;
    localparam int unsigned DivBits  = 4;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_AND   = 5'd2,
        OP_OR    = 5'd3,
        OP_NOR   = 5'd4,
        OP_SLT   = 5'd5,
        OP_SLTU  = 5'd6,
        OP_SLL   = 5'd7,
        OP_SRL   = 5'd8,
        OP_MUL   = 5'd9,
        OP_DIV   = 5'd10,
        OP_LUI   = 5'd11,
        OP_ADDI  = 5'd12,
        OP_ANDI  = 5'd13,
        OP_ORI   = 5'd14,
        OP_SLTI  = 5'd15,
        OP_SLTIU = 5'd16
    } t_op;

    typedef struct packed {
        logic [4:0]  action;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [15:0] immediate;
        logic [4:0]  shift_amount;
    } t_in_word;

    typedef struct packed {
        logic [31:0] result;
        logic        divide_by_zero;
    } t_out_word;

    // Divider pipeline payload: partial remainder, quotient/dividend shift
    // register, magnitude of divisor, sign of quotient.
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic        neg;
    } t_div_word;

endpackage

### hdl/rialu_div_stage.sv
// One restoring-division stage: retires a fixed number of quotient bits.
module rialu_div_stage #(
    parameter int unsigned BITS = 4
) (
    input  rialu_pkg::t_div_word i_d,
    output rialu_pkg::t_div_word o_d
);
    rialu_pkg::t_div_word w [0:BITS];
    logic [32:0] w_try [0:BITS-1];

    assign w[0] = i_d;
    assign o_d  = w[BITS];

    for (genvar k = 0; k < BITS; k++) begin : g_bit
        always_comb begin
            w_try[k] = {w[k].rem[31:0], w[k].quo[31]} - {1'b0, w[k].dvs};
            w[k+1]   = w[k];
            if (!w_try[k][32]) begin
                w[k+1].rem = w_try[k];
                w[k+1].quo = {w[k].quo[30:0], 1'b1};
            end else begin
                w[k+1].rem = {w[k].rem[31:0], w[k].quo[31]};
                w[k+1].quo = {w[k].quo[30:0], 1'b0};
            end
        end
    end
endmodule

### hdl/risc_integer_alu.sv
// Top level: pipelined 32-bit integer ALU.
//
// Input channel i_in_valid / o_in_stall carries one instruction word
// (operation, rs, rt, immediate, shift amount); output channel
// o_out_valid / i_out_stall returns one result word per input word, in
// order. A word is taken on an edge where valid is high and stall is low.
// Ten register stages: stage 0 decode and operand prep, 8 divide
// stages of 4 quotient bits each, then the output register, which also
// takes the quotient sign fixup. Throughput: one word per cycle while the
// receiver does not stall. The divider's restoring chain sets the depth;
// simple ops ride along in the same pipe. The multiplier is split into
// three 16x16 partial products in stage 0 summed in stage 1.
// Reset (synchronous, active low) clears all valid bits; payloads are
// not reset. When the receiver stalls, the output register holds its word
// and a stage behind it holds only once every stage ahead of it is full;
// empty slots ahead collapse, and o_in_stall rises only when stage 0
// cannot advance.
module risc_integer_alu (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rialu_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rialu_pkg::t_out_word  o_out_word
);
    localparam int unsigned NS   = rialu_pkg::DivSteps + 2;
    localparam int unsigned BITS = rialu_pkg::DivBits;

    typedef struct packed {
        logic [31:0]       simple;
        logic              is_div;
        logic              is_mul;
        logic              dz;
        logic [31:0]       pp_ll;
        logic [31:0]       pp_lh;
        logic [31:0]       pp_hl;
    } t_side;

    // Stage registers: index 0 after prep, NS-1 is the output stage.
    logic                  r_v  [0:NS-1];
    rialu_pkg::t_div_word  r_d  [0:NS-1];
    t_side                 r_s  [0:NS-1];
    logic                  w_adv [0:NS-1];
    rialu_pkg::t_div_word  w_dn [0:NS-1];

    // Stage 0 prep.
    rialu_pkg::t_op w_op;
    logic [31:0] w_a, w_b, w_sx, w_zx, w_ma, w_mb;
    t_side       n_s0;
    rialu_pkg::t_div_word n_d0;

    always_comb begin
        w_op = rialu_pkg::t_op'(i_in_word.action);
        w_a  = i_in_word.operand_a;
        w_b  = i_in_word.operand_b;
        w_sx = {{16{i_in_word.immediate[15]}}, i_in_word.immediate};
        w_zx = {16'h0000, i_in_word.immediate};
        w_ma = w_a[31] ? 32'(-w_a) : w_a;
        w_mb = w_b[31] ? 32'(-w_b) : w_b;
        n_s0 = '0;
        unique case (w_op)
            rialu_pkg::OP_ADD:   n_s0.simple = w_a + w_b;
            rialu_pkg::OP_SUB:   n_s0.simple = w_a - w_b;
            rialu_pkg::OP_AND:   n_s0.simple = w_a & w_b;
            rialu_pkg::OP_OR:    n_s0.simple = w_a | w_b;
            rialu_pkg::OP_NOR:   n_s0.simple = ~(w_a | w_b);
            rialu_pkg::OP_SLT:   n_s0.simple = {31'd0, $signed(w_a) < $signed(w_b)};
            rialu_pkg::OP_SLTU:  n_s0.simple = {31'd0, w_a < w_b};
            rialu_pkg::OP_SLL:   n_s0.simple = w_b << i_in_word.shift_amount;
            rialu_pkg::OP_SRL:   n_s0.simple = w_b >> i_in_word.shift_amount;
            rialu_pkg::OP_MUL:   n_s0.is_mul = 1'b1;
            rialu_pkg::OP_DIV: begin
                n_s0.is_div = (w_b != 32'd0);
                n_s0.dz     = (w_b == 32'd0);
            end
            rialu_pkg::OP_LUI:   n_s0.simple = {i_in_word.immediate, 16'h0000};
            rialu_pkg::OP_ADDI:  n_s0.simple = w_a + w_sx;
            rialu_pkg::OP_ANDI:  n_s0.simple = w_a & w_zx;
            rialu_pkg::OP_ORI:   n_s0.simple = w_a | w_zx;
            rialu_pkg::OP_SLTI:  n_s0.simple = {31'd0, $signed(w_a) < $signed(w_sx)};
            rialu_pkg::OP_SLTIU: n_s0.simple = {31'd0, w_a < w_sx};
            default:             n_s0.simple = 32'd0;
        endcase
        n_s0.pp_ll = w_a[15:0]  * w_b[15:0];
        n_s0.pp_lh = w_a[15:0]  * w_b[31:16];
        n_s0.pp_hl = w_a[31:16] * w_b[15:0];
        n_d0.rem = 33'd0;
        n_d0.quo = w_ma;
        n_d0.dvs = w_mb;
        n_d0.neg = w_a[31] ^ w_b[31];
    end

    // Divide steps between registers 0..DivSteps-1; stage NS-1 is plain.
    for (genvar g = 0; g < NS - 1; g++) begin : g_div
        if (g < rialu_pkg::DivSteps) begin : g_step
            rialu_div_stage #(.BITS(BITS)) u_stage (.i_d(r_d[g]), .o_d(w_dn[g]));
        end else begin : g_pass
            assign w_dn[g] = r_d[g];
        end
    end
    assign w_dn[NS-1] = r_d[NS-1];

    // Advance chain: a stage loads when its successor is free or moving.
    always_comb begin
        w_adv[NS-1] = !r_v[NS-1] || !i_out_stall;
        for (int i = NS - 2; i >= 0; i--) begin
            w_adv[i] = !r_v[i] || w_adv[i+1];
        end
    end

    assign o_in_stall = !w_adv[0];

    // Stage 1 folds the multiply partial products.
    t_side w_s1;
    always_comb begin
        w_s1 = r_s[0];
        if (r_s[0].is_mul) begin
            w_s1.simple = r_s[0].pp_ll + {r_s[0].pp_lh[15:0], 16'h0000}
                        + {r_s[0].pp_hl[15:0], 16'h0000};
        end
    end

    // Final: choose quotient or side result.
    logic [31:0] w_q;
    rialu_pkg::t_out_word n_out;
    always_comb begin
        w_q = r_d[NS-2].neg ? 32'(-r_d[NS-2].quo) : r_d[NS-2].quo;
        n_out.result         = r_s[NS-2].is_div ? w_q : r_s[NS-2].simple;
        n_out.divide_by_zero = r_s[NS-2].dz;
    end

    rialu_pkg::t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_v[i] <= 1'b0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_in_valid;
            for (int i = 1; i < NS; i++) begin
                if (w_adv[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_d[0] <= n_d0;
            r_s[0] <= n_s0;
        end
        if (w_adv[1]) begin
            r_d[1] <= w_dn[0];
            r_s[1] <= w_s1;
        end
        for (int i = 2; i < NS - 1; i++) begin
            if (w_adv[i]) begin
                r_d[i] <= w_dn[i-1];
                r_s[i] <= r_s[i-1];
            end
        end
        if (w_adv[NS-1]) begin
            r_out     <= n_out;
            r_d[NS-1] <= w_dn[NS-2];
            r_s[NS-1] <= r_s[NS-2];
        end
    end

    assign o_out_valid = r_v[NS-1];
    assign o_out_word  = r_out;
endmodule

### tb/tb_risc_integer_alu.sv
// Testbench for the pipelined integer ALU: random and directed words, scoreboard check.
`timescale 1ns / 100ps

module tb_risc_integer_alu;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned DrainCycles = 20;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    rialu_pkg::t_in_word  i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    rialu_pkg::t_out_word o_out_word;

    risc_integer_alu u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // Words waiting to be driven, and results predicted for accepted words.
    rialu_pkg::t_in_word  pending_words[$];
    rialu_pkg::t_out_word alu_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned result_count;
    int unsigned cycle_count;
    int unsigned div_zero_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Append one word to the driver queue.
    task enqueue_word(input rialu_pkg::t_in_word w);
        pending_words = {pending_words, w};
    endtask

    // Sign-extend the 16-bit immediate.
    function automatic logic [31:0] sext16(input logic [15:0] imm);
        return {{16{imm[15]}}, imm};
    endfunction

    // Expected result word for one instruction word.
    function automatic rialu_pkg::t_out_word alu_predict(input rialu_pkg::t_in_word w);
        rialu_pkg::t_out_word r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [63:0] prod;
        a = w.operand_a;
        b = w.operand_b;
        r = '0;
        case (w.action)
            rialu_pkg::OP_ADD:   r.result = a + b;
            rialu_pkg::OP_SUB:   r.result = a - b;
            rialu_pkg::OP_AND:   r.result = a & b;
            rialu_pkg::OP_OR:    r.result = a | b;
            rialu_pkg::OP_NOR:   r.result = ~(a | b);
            rialu_pkg::OP_SLT:   r.result = {31'd0, $signed(a) < $signed(b)};
            rialu_pkg::OP_SLTU:  r.result = {31'd0, a < b};
            rialu_pkg::OP_SLL:   r.result = b << w.shift_amount;
            rialu_pkg::OP_SRL:   r.result = b >> w.shift_amount;
            rialu_pkg::OP_MUL: begin
                prod = {32'd0, a} * {32'd0, b};
                r.result = prod[31:0];
            end
            rialu_pkg::OP_DIV: begin
                if (b == '0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    // magnitudes, unsigned divide, then fix sign; MIN / -1 wraps
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q  = ma / mb;
                    r.result = (a[31] != b[31]) ? -q : q;
                end
            end
            rialu_pkg::OP_LUI:   r.result = {w.immediate, 16'd0};
            rialu_pkg::OP_ADDI:  r.result = a + sext16(w.immediate);
            rialu_pkg::OP_ANDI:  r.result = a & {16'd0, w.immediate};
            rialu_pkg::OP_ORI:   r.result = a | {16'd0, w.immediate};
            rialu_pkg::OP_SLTI:
                r.result = {31'd0, $signed(a) < $signed(sext16(w.immediate))};
            rialu_pkg::OP_SLTIU: r.result = {31'd0, a < sext16(w.immediate)};
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic rialu_pkg::t_in_word make_word(input logic [4:0] op,
                                                      input logic [31:0] a,
                                                      input logic [31:0] b,
                                                      input logic [15:0] imm,
                                                      input logic [4:0] sh);
        rialu_pkg::t_in_word w;
        w.action = op;
        w.operand_a = a;
        w.operand_b = b;
        w.immediate = imm;
        w.shift_amount = sh;
        return w;
    endfunction

    // Operands biased toward corner values so compares, overflow and
    // the divider edges get hit often.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'(int'($urandom_range(0, 20)) - 10);
            5: return {16'd0, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Driver: presents the head of the queue, holds it while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word  <= pending_words.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: predict on input accept, compare on output accept.
    always @(posedge i_clk) begin
        rialu_pkg::t_out_word exp_word;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (i_in_valid && !o_in_stall) begin
                alu_results = {alu_results, alu_predict(i_in_word)};
                if (i_in_word.action == rialu_pkg::OP_DIV && i_in_word.operand_b == '0) begin
                    div_zero_count <= div_zero_count + 1;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                result_count <= result_count + 1;
                if (alu_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_out_word);
                    error_count <= error_count + 1;
                end else begin
                    exp_word = alu_results.pop_front();
                    if (o_out_word.result !== exp_word.result) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, exp_word.result, o_out_word.result);
                        error_count <= error_count + 1;
                    end
                    if (o_out_word.divide_by_zero !== exp_word.divide_by_zero) begin
                        $display("%0t: divide_by_zero mismatch expected %b actual %b",
                                 $time, exp_word.divide_by_zero, o_out_word.divide_by_zero);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        i_rst_n        = 1'b0;
        send_idle_pct  = 24;
        recv_idle_pct  = 78;
        error_count    = 0;
        result_count   = 0;
        cycle_count    = 0;
        div_zero_count = 0;

        // Directed: every op at corners, the divider special cases, SLTIU immediates, unused codes and a zero shift.
        for (int op = 0; op <= 16; op++) begin
            enqueue_word(make_word(5'(op), 32'h8000_0001, 32'hFFFF_FFFF, 16'h8000, 5'd31));
        end
        enqueue_word(make_word(rialu_pkg::OP_DIV, 32'h1234_5678, 32'd0, 16'hFFFF, 5'd0));
        enqueue_word(make_word(rialu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0, 5'd0));
        enqueue_word(make_word(rialu_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2, 16'h0, 5'd0));
        enqueue_word(make_word(rialu_pkg::OP_SLTIU, 32'hFFFF_FFFE, 32'd0, 16'hFFFF, 5'd0));
        enqueue_word(make_word(rialu_pkg::OP_SLTIU, 32'd5, 32'd0, 16'h7FFF, 5'd0));
        enqueue_word(make_word(5'd17, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31));
        enqueue_word(make_word(5'd31, 32'h0, 32'h0, 16'h0, 5'd0));
        enqueue_word(make_word(rialu_pkg::OP_SLL, 32'h0, 32'hFFFF_FFFF, 16'h0, 5'd0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random words in three idle phases.
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 78;
                recv_idle_pct = 24;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 510; n++) begin
                rialu_pkg::t_in_word w;
                w.action = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                                        : 5'($urandom_range(0, 16));
                w.operand_a = rand_operand();
                w.operand_b = rand_operand();
                w.immediate = 16'($urandom);
                w.shift_amount = 5'($urandom);
                enqueue_word(w);
            end
            while (pending_words.size() != 0) @(posedge i_clk);
        end

        while (i_in_valid) @(posedge i_clk);
        while (alu_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("covered %0d result words, all 17 ops plus unused codes, %0d divides by zero",
                 result_count, div_zero_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
